FILE: src/x86_logic_shift_unit_defines.svh
// Assertion macros shared by the x86 logic and shift unit.
`ifndef X86_LOGIC_SHIFT_UNIT_DEFINES_SVH
`define X86_LOGIC_SHIFT_UNIT_DEFINES_SVH

// Antecedent in this cycle implies consequent in the same cycle.
`define X86LSU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define X86LSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/x86lsu_pkg.sv
package x86lsu_pkg;

    localparam int DATA_W = 32;

    // operation codes
    localparam logic [3:0] CMD_AND   = 4'd0;
    localparam logic [3:0] CMD_OR    = 4'd1;
    localparam logic [3:0] CMD_XOR   = 4'd2;
    localparam logic [3:0] CMD_TEST  = 4'd3;
    localparam logic [3:0] CMD_NOT   = 4'd4;
    localparam logic [3:0] CMD_SHL   = 4'd5;
    localparam logic [3:0] CMD_SHR   = 4'd6;
    localparam logic [3:0] CMD_SAR   = 4'd7;
    localparam logic [3:0] CMD_ROL   = 4'd8;
    localparam logic [3:0] CMD_SETCC = 4'd9;

    // operand size codes
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_WORD = 2'd1;

    // setcc condition pairs (condition code without its invert bit)
    localparam logic [2:0] CC_O  = 3'd0;
    localparam logic [2:0] CC_B  = 3'd1;
    localparam logic [2:0] CC_E  = 3'd2;
    localparam logic [2:0] CC_BE = 3'd3;
    localparam logic [2:0] CC_S  = 3'd4;
    localparam logic [2:0] CC_P  = 3'd5;
    localparam logic [2:0] CC_L  = 3'd6;

    typedef struct packed {
        logic [3:0]        command;
        logic [1:0]        size_code;
        logic [DATA_W-1:0] dest_value;
        logic [DATA_W-1:0] src_value;
        logic [3:0]        condition;
        logic              carry_in;
        logic              overflow_in;
        logic              zero_in;
        logic              sign_in;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              write_back;
        logic              carry_out;
        logic              overflow_out;
        logic              zero_out;
        logic              sign_out;
        logic              unsupported;
    } t_result;

endpackage

FILE: src/x86lsu_exec.sv
module x86lsu_exec
    import x86lsu_pkg::*;
(
    input  t_in_item i_item,
    output t_result  o_result
);

    logic [31:0] mask;
    logic [31:0] dst_m;
    logic [4:0]  cnt;
    logic [31:0] sx;
    logic [15:0] rot8_w;
    logic [31:0] rot16_w;
    logic [63:0] rot32_w;
    logic [31:0] rot_res;
    logic        rot_msb;
    logic [31:0] res;
    logic        msb;
    logic        zs;
    logic        hold;
    logic        wb;
    logic        cf;
    logic        of;
    logic        uns;

    always_comb begin
        unique case (i_item.size_code)
            SZ_BYTE: begin
                mask = 32'h0000_00ff;
                sx   = {{24{i_item.dest_value[7]}}, i_item.dest_value[7:0]};
            end
            SZ_WORD: begin
                mask = 32'h0000_ffff;
                sx   = {{16{i_item.dest_value[15]}}, i_item.dest_value[15:0]};
            end
            default: begin
                mask = 32'hffff_ffff;
                sx   = i_item.dest_value;
            end
        endcase
    end

    assign dst_m = i_item.dest_value & mask;
    assign cnt   = i_item.src_value[4:0];

    // barrel rotators, count taken modulo each width
    assign rot8_w  = {i_item.dest_value[7:0], i_item.dest_value[7:0]} << cnt[2:0];
    assign rot16_w = {i_item.dest_value[15:0], i_item.dest_value[15:0]} << cnt[3:0];
    assign rot32_w = {i_item.dest_value, i_item.dest_value} << cnt;

    always_comb begin
        unique case (i_item.size_code)
            SZ_BYTE: begin
                rot_res = {24'd0, rot8_w[15:8]};
                rot_msb = rot8_w[15];
            end
            SZ_WORD: begin
                rot_res = {16'd0, rot16_w[31:16]};
                rot_msb = rot16_w[31];
            end
            default: begin
                rot_res = rot32_w[63:32];
                rot_msb = rot32_w[63];
            end
        endcase
    end

    always_comb begin
        res  = '0;
        zs   = 1'b0;
        hold = 1'b0;
        wb   = 1'b0;
        cf   = i_item.carry_in;
        of   = i_item.overflow_in;
        uns  = 1'b0;
        unique case (i_item.command)
            CMD_AND, CMD_TEST: begin
                res = dst_m & i_item.src_value;
                zs  = 1'b1;
                wb  = (i_item.command != CMD_TEST);
                cf  = 1'b0;
                of  = 1'b0;
            end
            CMD_OR: begin
                res = (i_item.dest_value | i_item.src_value) & mask;
                zs  = 1'b1;
                wb  = 1'b1;
                cf  = 1'b0;
                of  = 1'b0;
            end
            CMD_XOR: begin
                res = (i_item.dest_value ^ i_item.src_value) & mask;
                zs  = 1'b1;
                wb  = 1'b1;
                cf  = 1'b0;
                of  = 1'b0;
            end
            CMD_NOT: begin
                res = ~i_item.dest_value & mask;
                wb  = 1'b1;
            end
            CMD_SHL: begin
                res = (i_item.dest_value << cnt) & mask;
                zs  = 1'b1;
                wb  = 1'b1;
            end
            CMD_SHR: begin
                res = dst_m >> cnt;
                zs  = 1'b1;
                wb  = 1'b1;
            end
            CMD_SAR: begin
                res = 32'($signed(sx) >>> cnt) & mask;
                zs  = 1'b1;
                wb  = 1'b1;
            end
            CMD_ROL: begin
                res = rot_res;
                wb  = 1'b1;
                if (cnt != 5'd0) begin
                    cf = rot_res[0];
                    if (cnt == 5'd1) begin
                        of = rot_msb ^ rot_res[0];
                    end
                end
            end
            CMD_SETCC: begin
                unique case (i_item.condition[3:1])
                    CC_O:    hold = i_item.overflow_in;
                    CC_B:    hold = i_item.carry_in;
                    CC_E:    hold = i_item.zero_in;
                    CC_BE:   hold = i_item.carry_in | i_item.zero_in;
                    CC_S:    hold = i_item.sign_in;
                    CC_P:    uns  = 1'b1;
                    CC_L:    hold = i_item.sign_in ^ i_item.overflow_in;
                    default: hold = i_item.zero_in | (i_item.sign_in ^ i_item.overflow_in);
                endcase
                if (!uns) begin
                    res = {31'd0, hold ^ i_item.condition[0]};
                    wb  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        unique case (i_item.size_code)
            SZ_BYTE: msb = res[7];
            SZ_WORD: msb = res[15];
            default: msb = res[31];
        endcase
    end

    assign o_result = {res, wb, cf, of,
                       (zs ? (res == 32'd0) : i_item.zero_in),
                       (zs ? msb : i_item.sign_in),
                       uns};

endmodule

FILE: src/x86_logic_shift_unit.sv
// x86 logic / shift / rotate / setcc unit.
// The operation is captured in the input register, then its result in the result register with the strobe.
// Throughput: one transfer per cycle; busy is never raised, the receiver cannot stall.
// Reset: synchronous, active low; clears the valid flags of both registers, payload is not reset.
`include "x86_logic_shift_unit_defines.svh"

module x86_logic_shift_unit
    import x86lsu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_in_item i_item,
    output logic     o_strobe,
    output t_result  o_result
);

    t_in_item r_in;
    logic     r_in_vld;
    t_result  n_out;
    t_result  r_out;
    logic     r_out_vld;

    // Every stage moves on every cycle, so the unit never holds off a transfer.
    assign busy = 1'b0;

    // Input register: captures the operation on each start transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_item;
        end
    end

    // Single-pass execute logic: logic ops, shifters, barrel rotator, condition decode.
    x86lsu_exec u_exec (
        .i_item   (r_in),
        .o_result (n_out)
    );

    // Result register: the strobe marks the single cycle the result is shown.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            r_out <= n_out;
        end
    end

    assign o_strobe = r_out_vld;
    assign o_result = r_out;

    `X86LSU_ASSERT_NEXT(a_in_capture, i_clk, i_rst_n, start, r_in_vld, "start not captured")
    `X86LSU_ASSERT_NEXT(a_out_follow, i_clk, i_rst_n, r_in_vld, o_strobe, "strobe missing")
    `X86LSU_ASSERT_NOW(a_no_spurious, i_clk, i_rst_n, o_strobe, $past(start, 2), "stray strobe")
    `X86LSU_ASSERT_NOW(a_unsup_nowb, i_clk, i_rst_n, o_strobe && o_result.unsupported,
        !o_result.write_back && (o_result.result == '0), "unsupported wrote back")

endmodule
